// ===== rtl/core/binary_heap_priority_queue_defines.svh =====
// Assertion macros shared by the heap priority queue RTL.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked property with reset disable.
`define BHPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("heap queue check failed");
// Checked property that also holds during reset.
`define BHPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("heap queue check failed");
`else
`define BHPQ_ASSERT(lbl, clk, rst, prop)
`define BHPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/bhpq_pkg.sv =====
// Shared types, constants and the key ordering function of the heap queue.
`timescale 1ns / 1ps
package bhpq_pkg;

  localparam int MAX_ENTRIES = 255;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 8;
  localparam int ADDR_W      = 8;
  localparam int MEM_DEPTH   = MAX_ENTRIES + 1;  // slot 0 is never used
  localparam int CFG_W       = 8;

  // Operation codes of an input beat.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic REG_HEAP_ORDER = 1'b0;
  localparam logic REG_CAPACITY   = 1'b1;

  // Heap order codes.
  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  // True when key a belongs strictly above key b in the given order.
  function automatic logic ranks_above(input logic order,
                                       input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
    logic r;
    if (order == ORDER_MIN) begin
      r = (a < b);
    end else begin
      r = (a > b);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/binary_heap_priority_queue.sv =====
// Binary heap priority queue: control, heap memory and result register.
//
// Usage: an input beat (in_valid/in_ready) carries an operation, a key and a
// payload. An insert places the entry in the heap; a remove returns the top
// entry. Every input beat yields exactly one result beat (out_valid/out_ready)
// with a status, the removed key and payload, and the entry count afterward.
// Configuration (heap_order, capacity) is written through cfg_we, cfg_addr and
// cfg_data while the queue is idle; the user must keep to this, the block does not enforce it.
// A refused insert or a remove on an empty heap goes straight to the result. An
// insert climbs one level per parent read and compare, and a remove reads the
// root and the last entry, then descends one level per child read and compare;
// either walk ends at the root or a leaf, or earlier when a compare ends it. A
// full heap of 255 entries has 8 levels. Each level costs one registered read of
// the heap memory and one compare-and-write step. One item is worked on at a
// time; the next item is not accepted until the result enters the output register.
// Reset clears the entry count, the order (largest on top) and sets capacity
// to 255; memory contents are not cleared, and only data from written slots is used.
// When the receiver stalls, the result holds in the output register and a
// further finished result waits in the queue until that register frees up.
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_defines.svh"

module binary_heap_priority_queue
  import bhpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_addr,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic signed [KEY_W-1:0] entry_key,
  input  logic [PAY_W-1:0]        entry_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [KEY_W-1:0] top_key,
  output logic [PAY_W-1:0]        top_payload,
  output logic [ADDR_W-1:0]       entry_count
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_RM_RD  = 8'b0000_1000,
    S_RM_LD  = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic              heap_order;
  logic [ADDR_W-1:0] capacity;

  // Working registers.
  logic [ADDR_W-1:0] count, count_next;
  logic [ADDR_W-1:0] slot, slot_next;     // sift position
  entry_t            hold, hold_next;     // entry being placed
  logic [1:0]        res_status, res_status_next;
  entry_t            res_top, res_top_next;

  // Heap memory, one write and two registered reads per cycle.
  entry_t            mem [0:MEM_DEPTH-1];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  entry_t            rd_data_a, rd_data_b;

  // Sift-down child selection.
  logic [ADDR_W:0]   child;
  logic              sel_right;
  entry_t            sel_entry;
  logic [ADDR_W-1:0] sel_addr;

  logic              res_take;

  assign in_ready = (state == S_IDLE);
  assign res_take = (state == S_DONE) && (!out_valid || out_ready);

  assign child     = {slot, 1'b0};
  assign sel_right = (child < {1'b0, count}) &&
                     ranks_above(heap_order, rd_data_b.key, rd_data_a.key);
  assign sel_entry = sel_right ? rd_data_b : rd_data_a;
  assign sel_addr  = child[ADDR_W-1:0] + {{(ADDR_W-1){1'b0}}, sel_right};

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

  // Sequencer: next state, working registers and memory access.
  always_comb begin
    state_next      = state;
    count_next      = count;
    slot_next       = slot;
    hold_next       = hold;
    res_status_next = res_status;
    res_top_next    = res_top;
    wr_en           = 1'b0;
    wr_addr         = slot;
    wr_data         = hold;
    rd_en           = 1'b0;
    rd_addr_a       = slot;
    rd_addr_b       = slot;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = STAT_DONE;
          res_top_next    = '0;
          hold_next.key     = entry_key;
          hold_next.payload = entry_payload;
          if (operation == OP_INSERT) begin
            if (count >= capacity) begin
              res_status_next = STAT_FULL;
              state_next      = S_DONE;
            end else begin
              count_next = count + 1'b1;
              slot_next  = count + 1'b1;
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = S_DONE;
            end else begin
              state_next = S_RM_RD;
            end
          end
        end
      end
      // Sift up: fetch the parent, or settle at the root.
      S_UP_RD: begin
        if (slot == ADDR_W'(1)) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr_a  = slot >> 1;
          state_next = S_UP_CMP;
        end
      end
      // Move the parent down if the new entry is strictly better.
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (ranks_above(heap_order, hold.key, rd_data_a.key)) begin
          wr_data    = rd_data_a;
          slot_next  = slot >> 1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      // Remove: fetch the root and the last entry.
      S_RM_RD: begin
        rd_en      = 1'b1;
        rd_addr_a  = ADDR_W'(1);
        rd_addr_b  = count;
        state_next = S_RM_LD;
      end
      S_RM_LD: begin
        res_top_next = rd_data_a;
        hold_next    = rd_data_b;
        count_next   = count - 1'b1;
        slot_next    = ADDR_W'(1);
        state_next   = S_DN_RD;
      end
      // Sift down: fetch both children, or settle when there are none.
      S_DN_RD: begin
        if (child > {1'b0, count}) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr_a  = child[ADDR_W-1:0];
          rd_addr_b  = child[ADDR_W-1:0] + 1'b1;
          state_next = S_DN_CMP;
        end
      end
      // Lift the better child if it beats the moving entry.
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (ranks_above(heap_order, sel_entry.key, hold.key)) begin
          wr_data    = sel_entry;
          slot_next  = sel_addr;
          state_next = S_DN_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      heap_order <= ORDER_MAX;
      capacity   <= ADDR_W'(MAX_ENTRIES);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_HEAP_ORDER: heap_order <= cfg_data[0];
          REG_CAPACITY:   capacity   <= cfg_data[ADDR_W-1:0];
          default:        ;
        endcase
      end
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    slot       <= slot_next;
    hold       <= hold_next;
    res_status <= res_status_next;
    res_top    <= res_top_next;
    if (res_take) begin
      status      <= res_status;
      top_key     <= res_top.key;
      top_payload <= res_top.payload;
      entry_count <= count;
    end
  end

  // Checks.
  `BHPQ_ASSERT(a_up_not_root, clk, rst, (state == S_UP_CMP) |-> (slot > ADDR_W'(1)))
  `BHPQ_ASSERT(a_dn_in_heap, clk, rst, (state == S_DN_CMP) |-> (child <= {1'b0, count}))
  `BHPQ_ASSERT(a_wr_not_zero, clk, rst, wr_en |-> (wr_addr != '0))
  `BHPQ_ASSERT(a_result_shown, clk, rst, res_take |=> out_valid)

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the binary heap priority queue.
`timescale 1ns / 1ps

module testbench
  import bhpq_pkg::*;
();

  // One reply of the queue, as it appears on the result port.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic [ADDR_W-1:0]       count;
  } reply_t;

  // A row of the directed stimulus: a beat, a beat with a known reply, or a register write.
  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    reply_t                  want;
    logic                    reg_idx;
    logic [CFG_W-1:0]        reg_data;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic                    cfg_addr;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    operation;
  logic signed [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0]        entry_payload;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] top_key;
  logic [PAY_W-1:0]        top_payload;
  logic [ADDR_W-1:0]       entry_count;

  binary_heap_priority_queue dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .entry_key    (entry_key),
    .entry_payload(entry_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .top_key      (top_key),
    .top_payload  (top_payload),
    .entry_count  (entry_count)
  );

  // Mirror of the heap: its slots, fill level and the register settings.
  entry_t           heap_slots [1:MAX_ENTRIES];
  int               heap_fill;
  logic             heap_order_now;
  logic [CFG_W-1:0] heap_cap_now;

  // Replies still owed by the queue, oldest first.
  reply_t    heap_replies [$];
  stim_row_t stim_rows [$];
  int        mismatches;

  // Sender and receiver pacing.
  bit sender_bursty;
  int burst_left;
  bit long_hold_req;

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  // True when key a sits strictly above key b in the current order.
  function automatic bit key_outranks(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
    bit r;
    if (heap_order_now == ORDER_MIN) begin
      r = (a < b);
    end else begin
      r = (a > b);
    end
    return r;
  endfunction

  // Applies one operation to the mirror heap and returns the reply it owes.
  function automatic reply_t heap_reply(input logic op, input logic signed [KEY_W-1:0] key,
                                        input logic [PAY_W-1:0] payload);
    reply_t r;
    entry_t moving;
    int     limit;
    int     pos;
    int     child;
    bit     settled;
    r = '0;
    r.status = STAT_DONE;
    limit = (int'(heap_cap_now) > MAX_ENTRIES) ? MAX_ENTRIES : int'(heap_cap_now);
    if (op == OP_INSERT) begin
      if (heap_fill >= limit) begin
        r.status = STAT_FULL;
      end else begin
        // Sift the new entry up past strictly worse parents.
        moving.key = key;
        moving.payload = payload;
        heap_fill++;
        pos = heap_fill;
        while (pos > 1 && key_outranks(moving.key, heap_slots[pos / 2].key)) begin
          heap_slots[pos] = heap_slots[pos / 2];
          pos = pos / 2;
        end
        heap_slots[pos] = moving;
      end
    end else if (heap_fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      // Take the root, then sift the former last entry down from the top.
      r.key = heap_slots[1].key;
      r.payload = heap_slots[1].payload;
      moving = heap_slots[heap_fill];
      heap_fill--;
      pos = 1;
      child = 2;
      settled = 1'b0;
      while (!settled && child <= heap_fill) begin
        if (child < heap_fill && key_outranks(heap_slots[child + 1].key, heap_slots[child].key))
        begin
          child++;
        end
        if (!key_outranks(heap_slots[child].key, moving.key)) begin
          settled = 1'b1;
        end else begin
          heap_slots[pos] = heap_slots[child];
          pos = child;
          child = child * 2;
        end
      end
      heap_slots[pos] = moving;
    end
    r.count = ADDR_W'(heap_fill);
    return r;
  endfunction

  // Gap before the next beat: bursts of back-to-back beats with random pauses.
  function automatic int sender_gap();
    int g;
    g = 0;
    if (sender_bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        g = $urandom_range(1, 8);
      end
    end
    return g;
  endfunction

  // Offers one beat and waits for it to be taken; the owed reply is queued on acceptance.
  task automatic send_op(input logic op, input logic signed [KEY_W-1:0] key,
                         input logic [PAY_W-1:0] payload, input bit known,
                         input reply_t want);
    int     gap;
    reply_t predicted;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    entry_key     <= key;
    entry_payload <= payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = heap_reply(op, key, payload);
    heap_replies.push_back(known ? want : predicted);
  endtask

  // Writes a register once every owed reply has come back.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (heap_replies.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_ORDER) begin
      heap_order_now = data[0];
    end else begin
      heap_cap_now = data;
    end
  endtask

  // Key mix: mostly random, some near zero for ties, some at the extremes.
  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] k;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      k = $urandom;
    end else if (pick < 17) begin
      k = int'($urandom_range(0, 6)) - 3;
    end else if (pick == 17) begin
      k = 32'sh7FFF_FFFF;
    end else if (pick == 18) begin
      k = 32'sh8000_0000;
    end else begin
      k = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
    end
    return k;
  endfunction

  task automatic send_random(input int count, input int insert_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_op(op, random_key(), PAY_W'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  function automatic stim_row_t item_row(input logic op, input logic signed [KEY_W-1:0] key,
                                         input logic [PAY_W-1:0] payload);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.key = key;
    r.payload = payload;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic op, input logic signed [KEY_W-1:0] key,
                                          input logic [PAY_W-1:0] payload,
                                          input logic [1:0] st,
                                          input logic signed [KEY_W-1:0] tkey,
                                          input logic [PAY_W-1:0] tpay,
                                          input logic [ADDR_W-1:0] cnt);
    stim_row_t r;
    r = item_row(op, key, payload);
    r.kind = ROW_KNOWN;
    r.want.status = st;
    r.want.key = tkey;
    r.want.payload = tpay;
    r.want.count = cnt;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic idx, input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Receiver: random ready patterns, with one long hold-off on request.
  initial begin
    int          hold_left;
    int          phase_cycle;
    logic [31:0] ready_mask;
    out_ready = 1'b0;
    hold_left = 0;
    phase_cycle = 0;
    ready_mask = '1;
    forever begin
      @(negedge clk);
      if (phase_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mask = '1;
          1: ready_mask = $urandom;
          2: ready_mask = $urandom | $urandom;
          default: ready_mask = $urandom & $urandom;
        endcase
      end
      phase_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_mask[phase_cycle % 32];
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 40) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Each reply beat is checked against the oldest owed reply.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (heap_replies.size() == 0) begin
        if (mismatches < 40) begin
          $display("%0t ns: reply beat with none owed, expected nothing, actual %0h %0h %0h %0h",
                   $time, status, top_key, top_payload, entry_count);
        end
        mismatches++;
      end else begin
        want = heap_replies.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("top_key", want.key, top_key);
        compare_field("top_payload", 32'(want.payload), 32'(top_payload));
        compare_field("entry_count", 32'(want.count), 32'(entry_count));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    logic [CFG_W-1:0] cap;
    int               drain_wait;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_HEAP_ORDER;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_INSERT;
    entry_key = '0;
    entry_payload = '0;
    mismatches = 0;
    heap_fill = 0;
    heap_order_now = ORDER_MAX;
    heap_cap_now = 8'd255;
    sender_bursty = 1'b1;
    burst_left = 0;
    long_hold_req = 1'b0;

    // Directed rows: empty and extreme cases, ties, order flips and capacity limits.
    stim_rows.push_back(known_row(OP_REMOVE, 0, 0, STAT_EMPTY, 0, 0, 0));
    stim_rows.push_back(known_row(OP_INSERT, 32'sh7FFF_FFFF, 8'hFF, STAT_DONE, 0, 0, 1));
    stim_rows.push_back(known_row(OP_INSERT, 32'sh8000_0000, 8'h00, STAT_DONE, 0, 0, 2));
    stim_rows.push_back(known_row(OP_INSERT, 0, 8'h5A, STAT_DONE, 0, 0, 3));
    stim_rows.push_back(known_row(OP_INSERT, 32'sh7FFF_FFFF, 8'h01, STAT_DONE, 0, 0, 4));
    stim_rows.push_back(known_row(OP_REMOVE, 0, 0, STAT_DONE, 32'sh7FFF_FFFF, 8'hFF, 3));
    stim_rows.push_back(item_row(OP_INSERT, -1, 8'hA5));
    stim_rows.push_back(item_row(OP_INSERT, -1, 8'h3C));
    stim_rows.push_back(reg_row(REG_HEAP_ORDER, CFG_W'(ORDER_MIN)));
    stim_rows.push_back(item_row(OP_REMOVE, 32'sh5555_5555, 8'hAA));
    stim_rows.push_back(item_row(OP_REMOVE, 32'shAAAA_AAAA, 8'h55));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(item_row(OP_INSERT, 32'sh8000_0000, 8'h77));
    stim_rows.push_back(reg_row(REG_CAPACITY, 8'd2));
    stim_rows.push_back(item_row(OP_INSERT, 5, 8'h12));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(item_row(OP_INSERT, 7, 8'h34));
    stim_rows.push_back(reg_row(REG_CAPACITY, 8'd0));
    stim_rows.push_back(item_row(OP_INSERT, 9, 8'h56));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(known_row(OP_REMOVE, 0, 0, STAT_EMPTY, 0, 0, 0));
    stim_rows.push_back(reg_row(REG_CAPACITY, 8'd1));
    stim_rows.push_back(item_row(OP_INSERT, 1, 8'h80));
    stim_rows.push_back(item_row(OP_INSERT, 2, 8'h81));
    stim_rows.push_back(item_row(OP_REMOVE, 0, 0));
    stim_rows.push_back(reg_row(REG_CAPACITY, 8'd255));
    stim_rows.push_back(reg_row(REG_HEAP_ORDER, CFG_W'(ORDER_MAX)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_data);
      end else begin
        send_op(stim_rows[i].op, stim_rows[i].key, stim_rows[i].payload,
                stim_rows[i].kind == ROW_KNOWN, stim_rows[i].want);
      end
    end

    // Fill to the full 255 entries without pauses, then drain past empty.
    sender_bursty = 1'b0;
    send_random(270, 100);
    sender_bursty = 1'b1;
    send_random(290, 5);

    // Mixed phases; the heap carries over while order and capacity change.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_HEAP_ORDER, CFG_W'($urandom_range(0, 1)));
      case (ph % 5)
        0: cap = 8'd255;
        1: cap = 8'd1;
        2: cap = 8'($urandom_range(2, 20));
        3: cap = 8'($urandom_range(1, 255));
        default: cap = (ph == 4) ? 8'd0 : 8'($urandom_range(200, 255));
      endcase
      write_reg(REG_CAPACITY, cap);
      sender_bursty = (ph % 3 != 2);
      if (ph == 6) begin
        // Long receiver hold-off while beats keep coming, so the input stalls.
        sender_bursty = 1'b0;
        long_hold_req = 1'b1;
      end
      send_random(130, $urandom_range(35, 75));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (heap_replies.size() != 0) @(posedge clk);
    for (drain_wait = 0; drain_wait < 40; drain_wait++) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
